// ===== rtl/acc_pkg.sv =====
// shared widths, reset values and result type for the alarm clock controller
package acc_pkg;

    localparam int W_BTN  = 5;
    localparam int W_HOUR = 5;
    localparam int W_MIN  = 6;
    localparam int W_MODE = 2;
    localparam int W_IN   = 16;
    localparam int W_OUT  = 24;

    localparam int HISTORY_DEPTH_DEF = 5;

    localparam logic [W_MIN-1:0]  SNOOZE_RST     = 6'd5;
    localparam logic [W_HOUR-1:0] ALARM_HOUR_RST = 5'd23;
    localparam logic [W_MIN-1:0]  ALARM_MIN_RST  = 6'd5;
    localparam logic [W_HOUR-1:0] HOUR_MAX       = 5'd23;
    localparam logic [W_MIN-1:0]  MIN_MAX        = 6'd59;
    localparam logic [W_MIN:0]    MIN_WRAP       = 7'd60;

    localparam int BTN_SET    = 0;
    localparam int BTN_UP     = 1;
    localparam int BTN_DOWN   = 2;
    localparam int BTN_ALARM  = 3;
    localparam int BTN_SNOOZE = 4;

    typedef struct packed {
        logic              buzzer_on;
        logic [W_MODE-1:0] mode_now;
        logic              alarm_armed;
        logic [W_HOUR-1:0] wake_hour;
        logic [W_MIN-1:0]  wake_minute;
        logic [W_BTN-1:0]  press_mask;
    } t_result;

endpackage

// ===== rtl/acc_core.sv =====
// button qualification, mode state machine and alarm time registers
module acc_core #(
    parameter int HISTORY_DEPTH = acc_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [acc_pkg::W_BTN-1:0]   i_levels,
    input  logic [acc_pkg::W_HOUR-1:0]  i_now_hour,
    input  logic [acc_pkg::W_MIN-1:0]   i_now_minute,
    input  logic [acc_pkg::W_MIN-1:0]   i_snooze_len,
    output acc_pkg::t_result            o_result
);
    import acc_pkg::*;

    localparam logic [W_MODE-1:0] MODE_NORMAL   = 2'd0;
    localparam logic [W_MODE-1:0] MODE_SET_HOUR = 2'd1;
    localparam logic [W_MODE-1:0] MODE_SET_MIN  = 2'd2;
    localparam logic [W_MODE-1:0] MODE_RING     = 2'd3;

    logic [W_MODE-1:0] r_mode, n_mode;
    logic              r_enable, n_enable;
    logic [W_HOUR-1:0] r_ahour, n_ahour;
    logic [W_MIN-1:0]  r_amin, n_amin;
    logic [W_HOUR-1:0] r_shour, n_shour;
    logic [W_MIN-1:0]  r_smin, n_smin;
    logic [W_BTN-1:0]  r_hist [HISTORY_DEPTH];
    logic [W_BTN-1:0]  n_hist [HISTORY_DEPTH];

    logic [W_BTN-1:0]  seen;
    logic [W_BTN-1:0]  press;
    logic [W_MIN-1:0]  sn_len;
    logic [W_HOUR-1:0] sn_hour;
    logic [W_MIN:0]    sn_sum;
    logic [W_HOUR-1:0] sn_hour_next;
    logic [W_MIN-1:0]  sn_min_next;

    always_comb begin
        seen = '0;
        for (int k = 0; k < HISTORY_DEPTH; k++) begin
            seen = seen | r_hist[k];
        end
        press = i_levels & ~seen;
        n_hist[0] = i_levels;
        for (int k = 1; k < HISTORY_DEPTH; k++) begin
            n_hist[k] = r_hist[k-1];
        end
    end

    // snooze target: clamped now plus clamped length, carry into hour
    always_comb begin
        sn_len  = (i_snooze_len > MIN_MAX) ? MIN_MAX : i_snooze_len;
        sn_hour = (i_now_hour > HOUR_MAX) ? HOUR_MAX : i_now_hour;
        sn_sum  = {1'b0, ((i_now_minute > MIN_MAX) ? MIN_MAX : i_now_minute)}
                  + {1'b0, sn_len};
        if (sn_sum >= MIN_WRAP) begin
            sn_min_next  = W_MIN'(sn_sum - MIN_WRAP);
            sn_hour_next = (sn_hour == HOUR_MAX) ? '0 : sn_hour + 5'd1;
        end else begin
            sn_min_next  = sn_sum[W_MIN-1:0];
            sn_hour_next = sn_hour;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_enable = r_enable;
        n_ahour  = r_ahour;
        n_amin   = r_amin;
        n_shour  = r_shour;
        n_smin   = r_smin;
        if (r_mode == MODE_RING) begin
            if (press[BTN_ALARM]) begin
                n_ahour  = r_shour;
                n_amin   = r_smin;
                n_enable = 1'b0;
                n_mode   = MODE_NORMAL;
            end else if (press[BTN_SNOOZE]) begin
                n_ahour = sn_hour_next;
                n_amin  = sn_min_next;
                n_mode  = MODE_NORMAL;
            end
        end else begin
            if (r_mode == MODE_SET_HOUR) begin
                if (press[BTN_UP]) begin
                    n_ahour = (r_ahour >= HOUR_MAX) ? '0 : r_ahour + 5'd1;
                end else if (press[BTN_DOWN]) begin
                    n_ahour = (r_ahour == '0) ? HOUR_MAX : r_ahour - 5'd1;
                end
            end else if (r_mode == MODE_SET_MIN) begin
                if (press[BTN_UP]) begin
                    n_amin = (r_amin >= MIN_MAX) ? '0 : r_amin + 6'd1;
                end else if (press[BTN_DOWN]) begin
                    n_amin = (r_amin == '0) ? MIN_MAX : r_amin - 6'd1;
                end
            end
            if (press[BTN_SET]) begin
                unique case (r_mode)
                    MODE_NORMAL:   n_mode = MODE_SET_HOUR;
                    MODE_SET_HOUR: n_mode = MODE_SET_MIN;
                    default:       n_mode = MODE_NORMAL;
                endcase
            end
            if (press[BTN_ALARM]) begin
                n_enable = ~r_enable;
            end
            if (n_enable && n_ahour == i_now_hour && n_amin == i_now_minute) begin
                n_shour = n_ahour;
                n_smin  = n_amin;
                n_mode  = MODE_RING;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NORMAL;
            r_enable <= 1'b0;
            r_ahour  <= ALARM_HOUR_RST;
            r_amin   <= ALARM_MIN_RST;
            r_shour  <= '0;
            r_smin   <= '0;
            for (int k = 0; k < HISTORY_DEPTH; k++) begin
                r_hist[k] <= '0;
            end
        end else if (i_step) begin
            r_mode   <= n_mode;
            r_enable <= n_enable;
            r_ahour  <= n_ahour;
            r_amin   <= n_amin;
            r_shour  <= n_shour;
            r_smin   <= n_smin;
            for (int k = 0; k < HISTORY_DEPTH; k++) begin
                r_hist[k] <= n_hist[k];
            end
        end
    end

    always_comb begin
        o_result.buzzer_on   = (n_mode == MODE_RING);
        o_result.mode_now    = n_mode;
        o_result.alarm_armed = n_enable;
        o_result.wake_hour   = n_ahour;
        o_result.wake_minute = n_amin;
        o_result.press_mask  = press;
    end

endmodule

// ===== rtl/alarm_clock_controller_top.sv =====
// alarm clock controller top level: stream ports, input and result registers
// One item per clock cycle while the output side takes results. An item is
// captured in an input register, press qualification, mode update and alarm
// time update are combinational, and the outcome lands in a result register.
// The alarm state updates as each item leaves the input register, so every
// item sees the state left by the one before it. While a result waits, an
// item is taken only into an empty input register. The user must write the
// snooze length on the cfg port while the block is idle; the block does not
// enforce it. It resets to five minutes and values above 59 act as 59.
module alarm_clock_controller_top #(
    parameter int HISTORY_DEPTH = acc_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [acc_pkg::W_MIN-1:0]  i_cfg_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // btn_set, btn_up, btn_down, btn_alarm, btn_snooze, now_hour[4:0], now_minute[5:0]
    input  logic [acc_pkg::W_IN-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // buzzer_on, mode_now[1:0], alarm_armed, wake_hour[4:0], wake_minute[5:0],
    // press_mask[4:0], zero fill[3:0]
    output logic [acc_pkg::W_OUT-1:0]  m_axis_tdata
);
    import acc_pkg::*;

    logic              r_in_valid;
    logic [W_IN-1:0]   r_in_data;
    logic              r_out_valid;
    t_result           r_out;
    logic [W_MIN-1:0]  r_snooze;
    logic              step;
    t_result           core_result;

    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;
    assign o_cfg_ready   = 1'b1;

    acc_core #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_levels     (r_in_data[W_BTN-1:0]),
        .i_now_hour   (r_in_data[W_BTN+W_HOUR-1:W_BTN]),
        .i_now_minute (r_in_data[W_BTN+W_HOUR+W_MIN-1:W_BTN+W_HOUR]),
        .i_snooze_len (r_snooze),
        .o_result     (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snooze <= SNOOZE_RST;
        end else if (i_cfg_valid) begin
            r_snooze <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.press_mask, r_out.wake_minute, r_out.wake_hour,
                            r_out.alarm_armed, r_out.mode_now, r_out.buzzer_on};

endmodule

// ===== sim/acc_checker.sv =====
`timescale 1ns / 1ps
// alarm clock controller checker: predicts each result from the accepted items and compares
module acc_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic                       o_cfg_ready,
    input  logic [acc_pkg::W_MIN-1:0]  i_cfg_data,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic [acc_pkg::W_IN-1:0]   s_axis_tdata,
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic [acc_pkg::W_OUT-1:0]  m_axis_tdata,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_results,
    output int                         o_rings,
    output int                         o_snoozes,
    output int                         o_dismissals,
    output logic [acc_pkg::W_HOUR-1:0] o_wake_hour,
    output logic [acc_pkg::W_MIN-1:0]  o_wake_minute
);
    import acc_pkg::*;

    localparam int MAX_PRINTS = 30;

    typedef enum logic [W_MODE-1:0] {
        MODE_NORMAL     = 2'd0,
        MODE_SET_HOUR   = 2'd1,
        MODE_SET_MINUTE = 2'd2,
        MODE_RINGING    = 2'd3
    } t_clock_mode;

    typedef struct packed {
        logic              buzzer;
        t_clock_mode       mode;
        logic              armed;
        logic [W_HOUR-1:0] hour;
        logic [W_MIN-1:0]  minute;
        logic [W_BTN-1:0]  press;
    } t_clock_status;

    t_clock_mode       mode;
    logic              armed;
    logic [W_HOUR-1:0] alarm_hour;
    logic [W_MIN-1:0]  alarm_minute;
    logic [W_HOUR-1:0] saved_hour;
    logic [W_MIN-1:0]  saved_minute;
    logic [W_MIN-1:0]  snooze_len;
    logic [W_BTN-1:0]  level_history [HISTORY_DEPTH_DEF];

    t_clock_status     due_status [$];
    t_clock_status     want;
    t_clock_status     next_status;
    int                mismatches = 0;
    int                compared = 0;
    int                rings = 0;
    int                snoozes = 0;
    int                dismissals = 0;

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        if (mismatches < MAX_PRINTS) begin
            $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp_val);
        end
        mismatches++;
    endtask

    task automatic tick_alarm_clock(input logic [W_IN-1:0] data, output t_clock_status st);
        logic [W_BTN-1:0]  levels;
        logic [W_HOUR-1:0] now_hour;
        logic [W_MIN-1:0]  now_minute;
        logic [W_BTN-1:0]  seen;
        logic [W_BTN-1:0]  press;
        logic [W_MIN-1:0]  len;
        logic [W_HOUR-1:0] h;
        logic [W_MIN:0]    m;
        levels     = data[W_BTN-1:0];
        now_hour   = data[W_BTN+W_HOUR-1:W_BTN];
        now_minute = data[W_BTN+W_HOUR+W_MIN-1:W_BTN+W_HOUR];
        seen = '0;
        for (int i = 0; i < HISTORY_DEPTH_DEF; i++) begin
            seen |= level_history[i];
        end
        press = levels & ~seen;
        for (int i = HISTORY_DEPTH_DEF - 1; i > 0; i--) begin
            level_history[i] = level_history[i-1];
        end
        level_history[0] = levels;

        if (mode == MODE_RINGING) begin
            if (press[BTN_ALARM]) begin
                alarm_hour   = saved_hour;
                alarm_minute = saved_minute;
                armed        = 1'b0;
                mode         = MODE_NORMAL;
                dismissals++;
            end else if (press[BTN_SNOOZE]) begin
                len = (snooze_len > MIN_MAX) ? MIN_MAX : snooze_len;
                h   = (now_hour > HOUR_MAX) ? HOUR_MAX : now_hour;
                m   = {1'b0, ((now_minute > MIN_MAX) ? MIN_MAX : now_minute)} + {1'b0, len};
                if (m >= MIN_WRAP) begin
                    m = m - MIN_WRAP;
                    h = (h == HOUR_MAX) ? '0 : h + 1'b1;
                end
                alarm_hour   = h;
                alarm_minute = m[W_MIN-1:0];
                mode         = MODE_NORMAL;
                snoozes++;
            end
        end else begin
            if (mode == MODE_SET_HOUR) begin
                if (press[BTN_UP]) begin
                    alarm_hour = (alarm_hour >= HOUR_MAX) ? '0 : alarm_hour + 1'b1;
                end else if (press[BTN_DOWN]) begin
                    alarm_hour = (alarm_hour == '0) ? HOUR_MAX : alarm_hour - 1'b1;
                end
            end else if (mode == MODE_SET_MINUTE) begin
                if (press[BTN_UP]) begin
                    alarm_minute = (alarm_minute >= MIN_MAX) ? '0 : alarm_minute + 1'b1;
                end else if (press[BTN_DOWN]) begin
                    alarm_minute = (alarm_minute == '0) ? MIN_MAX : alarm_minute - 1'b1;
                end
            end
            if (press[BTN_SET]) begin
                case (mode)
                    MODE_NORMAL:   mode = MODE_SET_HOUR;
                    MODE_SET_HOUR: mode = MODE_SET_MINUTE;
                    default:       mode = MODE_NORMAL;
                endcase
            end
            if (press[BTN_ALARM]) begin
                armed = ~armed;
            end
            if (armed && alarm_hour == now_hour && alarm_minute == now_minute) begin
                saved_hour   = alarm_hour;
                saved_minute = alarm_minute;
                mode         = MODE_RINGING;
                rings++;
            end
        end

        st.buzzer = (mode == MODE_RINGING);
        st.mode   = mode;
        st.armed  = armed;
        st.hour   = alarm_hour;
        st.minute = alarm_minute;
        st.press  = press;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode         = MODE_NORMAL;
            armed        = 1'b0;
            alarm_hour   = ALARM_HOUR_RST;
            alarm_minute = ALARM_MIN_RST;
            saved_hour   = '0;
            saved_minute = '0;
            snooze_len   = SNOOZE_RST;
            for (int i = 0; i < HISTORY_DEPTH_DEF; i++) begin
                level_history[i] = '0;
            end
            due_status.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_status.size() == 0) begin
                    report_mismatch("result with none due", int'(m_axis_tdata), 0);
                end else begin
                    want = due_status.pop_front();
                    compared++;
                    if (m_axis_tdata[0] !== want.buzzer)
                        report_mismatch("buzzer_on", int'(m_axis_tdata[0]), int'(want.buzzer));
                    if (m_axis_tdata[2:1] !== want.mode)
                        report_mismatch("mode_now", int'(m_axis_tdata[2:1]), int'(want.mode));
                    if (m_axis_tdata[3] !== want.armed)
                        report_mismatch("alarm_armed", int'(m_axis_tdata[3]), int'(want.armed));
                    if (m_axis_tdata[8:4] !== want.hour)
                        report_mismatch("wake_hour", int'(m_axis_tdata[8:4]), int'(want.hour));
                    if (m_axis_tdata[14:9] !== want.minute)
                        report_mismatch("wake_minute", int'(m_axis_tdata[14:9]),
                                        int'(want.minute));
                    if (m_axis_tdata[19:15] !== want.press)
                        report_mismatch("press_mask", int'(m_axis_tdata[19:15]),
                                        int'(want.press));
                    if (m_axis_tdata[23:20] !== 4'd0)
                        report_mismatch("zero fill", int'(m_axis_tdata[23:20]), 0);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                snooze_len = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                tick_alarm_clock(s_axis_tdata, next_status);
                due_status.push_back(next_status);
            end
        end
        o_fail_count  <= mismatches;
        o_pending     <= due_status.size();
        o_results     <= compared;
        o_rings       <= rings;
        o_snoozes     <= snoozes;
        o_dismissals  <= dismissals;
        o_wake_hour   <= alarm_hour;
        o_wake_minute <= alarm_minute;
    end

endmodule

// ===== sim/tb_alarm_clock_controller_top.sv =====
`timescale 1ns / 1ps
// alarm clock controller testbench top: clock, reset, stimulus, snooze settings and verdict
module tb_alarm_clock_controller_top;
    import acc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_TICKS = 88;
    localparam int HOLD_CYCLES = 150;
    localparam logic [W_BTN-1:0] PUSH_SET    = W_BTN'(1 << BTN_SET);
    localparam logic [W_BTN-1:0] PUSH_UP     = W_BTN'(1 << BTN_UP);
    localparam logic [W_BTN-1:0] PUSH_DOWN   = W_BTN'(1 << BTN_DOWN);
    localparam logic [W_BTN-1:0] PUSH_ALARM  = W_BTN'(1 << BTN_ALARM);
    localparam logic [W_BTN-1:0] PUSH_SNOOZE = W_BTN'(1 << BTN_SNOOZE);

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [W_MIN-1:0]  i_cfg_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [W_IN-1:0]   s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [W_OUT-1:0]  m_axis_tdata;

    int                fail_count;
    int                pending;
    int                results;
    int                rings;
    int                snoozes;
    int                dismissals;
    logic [W_HOUR-1:0] wake_hour;
    logic [W_MIN-1:0]  wake_minute;

    int                cycles = 0;
    int                ticks_sent = 0;
    int                settings_used = 1;
    int                hold_req = 0;
    bit                burst = 1'b0;
    logic [W_HOUR-1:0] clock_hour = '0;
    logic [W_MIN-1:0]  clock_minute = '0;

    alarm_clock_controller_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    acc_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results     (results),
        .o_rings       (rings),
        .o_snoozes     (snoozes),
        .o_dismissals  (dismissals),
        .o_wake_hour   (wake_hour),
        .o_wake_minute (wake_minute)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycles, pending);
            $display("[alarm_clock_controller_top] ERROR");
            $finish;
        end
    end

    task automatic send_tick(input logic [W_BTN-1:0] levels, input logic [W_HOUR-1:0] hour,
                             input logic [W_MIN-1:0] minute);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {minute, hour, levels};
        do @(posedge i_clk); while (!s_axis_tready);
        ticks_sent++;
    endtask

    task automatic timed_tick(input logic [W_BTN-1:0] levels);
        int                r;
        logic [W_HOUR-1:0] hour;
        logic [W_MIN-1:0]  minute;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            hour   = wake_hour;
            minute = wake_minute;
        end else if (r < 45) begin
            hour   = W_HOUR'($urandom_range(0, 31));
            minute = W_MIN'($urandom_range(0, 63));
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                if (clock_minute == MIN_MAX) begin
                    clock_minute = '0;
                    clock_hour   = (clock_hour == HOUR_MAX) ? '0 : clock_hour + 1'b1;
                end else begin
                    clock_minute = clock_minute + 1'b1;
                end
            end
            hour   = clock_hour;
            minute = clock_minute;
        end
        send_tick(levels, hour, minute);
    endtask

    // mostly clean presses after a quiet stretch, some early or held presses, some noise
    task automatic random_action();
        int               quiet_n;
        int               repeats;
        logic [W_BTN-1:0] mask;
        if ($urandom_range(0, 99) < 15) begin
            timed_tick(W_BTN'($urandom_range(0, 31)));
        end else begin
            case ($urandom_range(0, 9))
                0, 1:    mask = PUSH_SET;
                2, 3:    mask = PUSH_UP;
                4, 5:    mask = PUSH_DOWN;
                6:       mask = PUSH_ALARM;
                7:       mask = PUSH_SNOOZE;
                8:       mask = PUSH_UP | PUSH_DOWN;
                default: mask = PUSH_ALARM | PUSH_SNOOZE;
            endcase
            quiet_n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) : HISTORY_DEPTH_DEF;
            repeats = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
            repeat (quiet_n) timed_tick('0);
            repeat (repeats) timed_tick(mask);
        end
    endtask

    task automatic write_snooze(input logic [W_MIN-1:0] value);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial begin
        int gap;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req > 0) begin
                gap      = hold_req;
                hold_req = 0;
            end else begin
                gap = burst ? 0 : $urandom_range(0, 19);
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        logic [W_MIN-1:0] snooze_set [6];
        int               phase_end;
        snooze_set[0] = 6'd0;
        snooze_set[1] = 6'd59;
        snooze_set[2] = 6'd63;
        snooze_set[3] = 6'd1;
        snooze_set[4] = W_MIN'($urandom_range(2, 58));
        snooze_set[5] = W_MIN'($urandom_range(0, 63));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part with the reset snooze length
        send_tick('0, 0, 0);
        send_tick(PUSH_SET, 0, 0);
        send_tick(PUSH_UP, 0, 0);
        send_tick(PUSH_DOWN, 0, 0);
        send_tick(PUSH_ALARM, 23, 5);
        send_tick(PUSH_SET | PUSH_UP | PUSH_DOWN, 23, 5);
        send_tick(PUSH_SNOOZE, 31, 63);
        repeat (5) send_tick('0, 0, 3);
        send_tick('0, 0, 4);
        send_tick(PUSH_ALARM | PUSH_SNOOZE, 0, 4);
        send_tick(PUSH_SET, 16, 32);
        send_tick(PUSH_SET, 15, 31);
        repeat (5) send_tick('0, 8, 48);
        send_tick(PUSH_SET | PUSH_DOWN, 7, 15);
        send_tick(PUSH_UP, 30, 62);

        for (int p = 0; p < 6; p++) begin
            write_snooze(snooze_set[p]);
            phase_end = ticks_sent + PHASE_TICKS;
            if (p == 1) begin
                // output side holds off while input runs flat out
                hold_req = HOLD_CYCLES;
                burst    = 1'b1;
                repeat (7) random_action();
            end
            while (ticks_sent < phase_end) begin
                burst = ($urandom_range(0, 3) == 0);
                random_action();
            end
            burst = 1'b0;
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);

        $display("ran %0d ticks over %0d snooze settings, %0d results compared",
                 ticks_sent, settings_used, results);
        $display("alarm rang %0d times, snoozed %0d, dismissed %0d", rings, snoozes, dismissals);
        if (fail_count == 0 && pending == 0) begin
            $display("[alarm_clock_controller_top] OK");
        end else begin
            $display("[alarm_clock_controller_top] ERROR");
        end
        $finish;
    end

endmodule
